[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/spq_pkg.sv]
`default_nettype none
package spq_pkg;
	localparam int unsigned MaxTracksDef    = 1024;
	localparam int unsigned HistoryDepthDef = 16;
	localparam logic [31:0] SeedDefault     = 32'h9E37_79B9;
	localparam int unsigned TrackW          = 10;
	localparam int unsigned CountW          = 11;
	localparam int unsigned FillW           = 5;

	typedef enum logic [2:0] {
		OP_RESTART = 3'd0,
		OP_ADVANCE = 3'd1,
		OP_PREVIOUS = 3'd2,
		OP_RETREAT = 3'd3,
		OP_SET_SHUFFLE = 3'd4
	} opcode_t;

	localparam logic [0:0] REG_TRACK_COUNT = 1'b0;
	localparam logic [0:0] REG_RANDOM_SEED = 1'b1;

	// One queued command word between the front and the back part.
	typedef struct packed {
		logic [2:0]        opcode;
		logic [TrackW-1:0] start_index;
		logic              wrap;
		logic              shuffle_on;
		logic              new_round;
	} cmd_t;

	// Result word.
	typedef struct packed {
		logic              ok;
		logic              has_track;
		logic [TrackW-1:0] current_track;
		logic [TrackW-1:0] cursor_pos;
		logic              shuffle_state;
		logic [FillW-1:0]  history_len;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RD_CUR,      // fetch order_table[cursor]
		ST_RD_CUR_W,
		ST_SEQ,         // sequential fill sweep
		ST_SWAP0,       // place current track first (new round)
		ST_SHUF_RND,    // draw random for shuffle step
		ST_SHUF_MUL,
		ST_SHUF_RDA,
		ST_SHUF_RDB,
		ST_SHUF_WRA,
		ST_SHUF_WRB,
		ST_FIX_CHK,     // wrap round: avoid finished track first
		ST_FIX_RND,
		ST_FIX_MUL,
		ST_FIX_RD,
		ST_FIX_WR0,
		ST_FIX_WRB,
		ST_SEARCH,      // scan table for popped track
		ST_SEARCH_W,
		ST_FINAL,       // fetch track at cursor for report
		ST_FINAL_W,
		ST_REPORT
	} bstate_t;

	function automatic logic [31:0] xorshift_next(input logic [31:0] s);
		logic [31:0] v;
		v = s;
		v = v ^ (v << 13);
		v = v ^ (v >> 17);
		v = v ^ (v << 5);
		return (v == 32'd0) ? SeedDefault : v;
	endfunction
endpackage
`default_nettype wire

[hdl/spq_front.sv]
`default_nettype none
module spq_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [15:0]   s_tdata,
	output logic               q_valid,
	input  wire logic          q_ready,
	output spq_pkg::cmd_t      q_cmd
);
	import spq_pkg::*;

	// Two-entry queue of unpacked commands.
	cmd_t     mem_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t     in_cmd;

	always_comb begin
		in_cmd.opcode      = s_tdata[2:0];
		in_cmd.start_index = s_tdata[12:3];
		in_cmd.wrap        = s_tdata[13];
		in_cmd.shuffle_on  = s_tdata[14];
		in_cmd.new_round   = s_tdata[15];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (s_tvalid && s_tready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, s_tvalid && s_tready} - {1'b0, q_valid && q_ready};
		end
	end
endmodule
`default_nettype wire

[hdl/spq_back.sv]
`default_nettype none
module spq_back #(
	parameter int unsigned MAX_TRACKS    = spq_pkg::MaxTracksDef,
	parameter int unsigned HISTORY_DEPTH = spq_pkg::HistoryDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  spq_pkg::cmd_t    q_cmd,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	output logic             r_valid,
	input  wire logic        r_ready,
	output spq_pkg::res_t    r_res
);
	import spq_pkg::*;

	localparam int unsigned AW = $clog2(MAX_TRACKS);
	localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	// Order table memory: one port, registered read.
	logic [TrackW-1:0] order_mem [MAX_TRACKS];
	logic [TrackW-1:0] rd_q;
	logic [AW-1:0]     addr;
	logic              mem_we;
	logic [TrackW-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) order_mem[addr] <= mem_wd;
		rd_q <= order_mem[addr];
	end

	logic [TrackW-1:0] hist_q [HISTORY_DEPTH];
	logic [FillW-1:0]  fill_q;
	logic [TrackW-1:0] cursor_q;
	logic              shuf_q, loaded_q;
	logic [CountW-1:0] count_q, tc_q;
	logic [31:0]       rng_q;
	bstate_t           st_q, st_d;
	cmd_t              cmd_q;
	logic              ok_q;
	logic [TrackW-1:0] cur_q, fin_q, pop_q, tmpa_q, tmpb_q;
	logic [CountW-1:0] idx_q, first_q, rem_q, pb_q;
	logic [42:0]       prod_s1;
	logic [CountW-1:0] chosen;
	logic              has_cur;
	logic              seq_round_q; // sweep belongs to a wrap round
	res_t              res_q;
	logic              rv_q;

	assign has_cur = loaded_q && (count_q != '0) && ({1'b0, cursor_q} < count_q);
	assign chosen  = prod_s1[42:32];
	assign q_ready = (st_q == ST_IDLE) && !rv_q;
	assign r_valid = rv_q;
	assign r_res   = res_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:     if (q_valid && q_ready) st_d = ST_DECODE;
			ST_DECODE:   st_d = ST_RD_CUR;
			ST_RD_CUR:   st_d = ST_RD_CUR_W;
			ST_RD_CUR_W: st_d = ST_FINAL; // reassigned in sequential block
			ST_FINAL:    st_d = ST_FINAL_W;
			ST_FINAL_W:  st_d = ST_REPORT;
			ST_REPORT:   st_d = ST_IDLE;
			default:     st_d = st_q;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wd = '0;
		addr   = '0;
		case (st_q)
			ST_RD_CUR, ST_FINAL, ST_FINAL_W: addr = cursor_q[AW-1:0];
			ST_SEQ: begin
				mem_we = 1'b1; addr = idx_q[AW-1:0]; mem_wd = idx_q[TrackW-1:0];
			end
			ST_SWAP0: begin
				mem_we = 1'b1;
				addr   = (idx_q == '0) ? '0 : cur_q[AW-1:0];
				mem_wd = (idx_q == '0) ? cur_q : '0;
			end
			ST_SHUF_RDA: addr = AW'(first_q + chosen);
			ST_SHUF_WRB: addr = pb_q[AW-1:0];
			ST_SHUF_RDB, ST_SHUF_WRA: addr = idx_q[AW-1:0];
			ST_FIX_CHK, ST_FIX_WR0: addr = '0;
			ST_FIX_RD: addr = (rem_q > 11'd1) ? AW'(11'd1 + chosen) : AW'(11'd1);
			ST_FIX_WRB: addr = pb_q[AW-1:0];
			ST_SEARCH: addr = idx_q[AW-1:0];
			default: addr = '0;
		endcase
		case (st_q)
			ST_SHUF_WRA: begin mem_we = 1'b1; mem_wd = tmpb_q; end
			ST_SHUF_WRB: begin mem_we = 1'b1; mem_wd = tmpa_q; end
			ST_FIX_WR0:  begin mem_we = 1'b1; mem_wd = rd_q; end
			ST_FIX_WRB:  begin mem_we = 1'b1; mem_wd = fin_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 43'(rng_q) * 43'(rem_q);
		if (st_q == ST_IDLE && q_valid && q_ready) cmd_q <= q_cmd;
	end

	// Pushing on advance: drop oldest when full.
	logic [TrackW-1:0] hist_n [HISTORY_DEPTH];
	logic              do_push;
	logic [FillW-1:0]  fill_push;
	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH; i++) hist_n[i] = hist_q[i];
		fill_push = fill_q;
		if (fill_q < FillW'(HISTORY_DEPTH)) begin
			hist_n[fill_q[HW-1:0]] = cur_q;
			fill_push = fill_q + 1'b1;
		end else begin
			for (int i = 0; i + 1 < HISTORY_DEPTH; i++) hist_n[i] = hist_q[i+1];
			hist_n[HISTORY_DEPTH-1] = cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= hist_n[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; fill_q <= '0; cursor_q <= '0; shuf_q <= 1'b0;
			loaded_q <= 1'b0; count_q <= '0; tc_q <= '0; rng_q <= SeedDefault;
			ok_q <= 1'b0; rv_q <= 1'b0; idx_q <= '0; first_q <= '0; rem_q <= '0;
			pb_q <= '0; cur_q <= '0; fin_q <= '0; pop_q <= '0; tmpa_q <= '0;
			seq_round_q <= 1'b0; res_q <= '0; do_push <= 1'b0;
		end else begin
			do_push <= 1'b0;
			if (rv_q && r_ready) rv_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == REG_TRACK_COUNT) tc_q <= cfg_wdata[CountW-1:0];
				else rng_q <= (cfg_wdata == '0) ? SeedDefault : cfg_wdata;
			end
			st_q <= st_d;
			case (st_q)
				ST_RD_CUR_W: begin
					cur_q <= rd_q;
					ok_q  <= 1'b0;
					st_q  <= ST_FINAL;
					case (cmd_q.opcode)
						OP_RESTART: begin
							if (!(({1'b0, tc_q} > 12'(MAX_TRACKS)) ||
							      ((tc_q == '0) ? (cmd_q.start_index != '0)
							                   : ({1'b0, cmd_q.start_index} >= tc_q)))) begin
								ok_q <= 1'b1; loaded_q <= 1'b1; count_q <= tc_q;
								cursor_q <= (tc_q == '0) ? '0 : cmd_q.start_index;
								shuf_q <= 1'b0; fill_q <= '0; idx_q <= '0;
								seq_round_q <= 1'b0;
								st_q <= (tc_q == '0) ? ST_FINAL : ST_SEQ;
							end
						end
						OP_ADVANCE: if (has_cur) begin
							fin_q <= rd_q;
							if ({1'b0, cursor_q} + 1'b1 < count_q) begin
								do_push <= 1'b1; cursor_q <= cursor_q + 1'b1; ok_q <= 1'b1;
							end else if (cmd_q.wrap) begin
								do_push <= 1'b1; ok_q <= 1'b1; cursor_q <= '0;
								if (shuf_q) begin
									idx_q <= '0; seq_round_q <= 1'b1; st_q <= ST_SEQ;
								end
							end
						end
						OP_PREVIOUS: if (has_cur && fill_q != '0) begin
							fill_q <= fill_q - 1'b1;
							pop_q  <= hist_q[HW'(fill_q - 1'b1)];
							idx_q  <= '0; st_q <= ST_SEARCH;
						end
						OP_RETREAT: if (has_cur) begin
							if (cursor_q != '0) begin
								cursor_q <= cursor_q - 1'b1; ok_q <= 1'b1;
							end else if (cmd_q.wrap) begin
								cursor_q <= TrackW'(count_q - 1'b1); ok_q <= 1'b1;
							end
						end
						OP_SET_SHUFFLE: begin
							ok_q <= 1'b1;
							shuf_q <= cmd_q.shuffle_on;
							if (cmd_q.shuffle_on != shuf_q && has_cur) begin
								idx_q <= '0; seq_round_q <= 1'b0;
								if (!cmd_q.shuffle_on) begin
									cursor_q <= rd_q; st_q <= ST_SEQ;
								end else if (cmd_q.new_round) begin
									cursor_q <= '0; st_q <= ST_SEQ;
								end else begin
									first_q <= CountW'(cursor_q) + 1'b1;
									rem_q <= count_q - CountW'(cursor_q) - 1'b1;
									st_q <= ST_SHUF_RND;
								end
							end
						end
						default: ;
					endcase
				end
				ST_SEQ: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q + 1'b1 >= count_q) begin
						idx_q <= '0;
						if (seq_round_q) begin
							first_q <= '0; rem_q <= count_q; st_q <= ST_SHUF_RND;
						end else if (cmd_q.opcode == OP_SET_SHUFFLE && cmd_q.shuffle_on) begin
							st_q <= ST_SWAP0;
						end else st_q <= ST_FINAL;
					end
				end
				ST_SWAP0: begin
					// first step writes cur at 0, second step writes 0 at cur
					if (idx_q == '0) idx_q <= 11'd1;
					else begin
						first_q <= 11'd1; rem_q <= count_q - 1'b1; st_q <= ST_SHUF_RND;
					end
				end
				ST_SHUF_RND: begin
					if (rem_q <= 11'd1) begin
						st_q <= seq_round_q ? ST_FIX_CHK : ST_FINAL;
					end else begin
						rng_q <= xorshift_next(rng_q); st_q <= ST_SHUF_MUL;
					end
				end
				ST_SHUF_MUL: begin
					idx_q <= first_q + rem_q - 1'b1; st_q <= ST_SHUF_RDA;
				end
				ST_SHUF_RDA: begin
					pb_q <= first_q + chosen;
					st_q <= ST_SHUF_RDB;
				end
				ST_SHUF_RDB: st_q <= ST_SHUF_WRA;
				ST_SHUF_WRA: begin tmpa_q <= rd_q; st_q <= ST_SHUF_WRB; end
				ST_SHUF_WRB: begin
					rem_q <= rem_q - 1'b1; st_q <= ST_SHUF_RND;
				end
				ST_FIX_CHK: st_q <= ST_FIX_RND;
				ST_FIX_RND: begin
					if (count_q > 11'd1 && rd_q == fin_q) begin
						// A bound of one picks position one without a draw.
						if (count_q > 11'd2) rng_q <= xorshift_next(rng_q);
						rem_q <= count_q - 1'b1;
						st_q <= ST_FIX_MUL;
					end else st_q <= ST_FINAL;
				end
				ST_FIX_MUL: begin
					if (rem_q <= 11'd1) begin
						pb_q <= 11'd1; rng_q <= rng_q;
					end
					st_q <= ST_FIX_RD;
				end
				ST_FIX_RD: begin
					if (rem_q > 11'd1) pb_q <= 11'd1 + chosen;
					st_q <= ST_FIX_WR0;
				end
				ST_FIX_WR0: st_q <= ST_FIX_WRB;
				ST_FIX_WRB: st_q <= ST_FINAL;
				ST_SEARCH: begin
					if (idx_q >= count_q) st_q <= ST_FINAL;
					else st_q <= ST_SEARCH_W;
				end
				ST_SEARCH_W: begin
					if (rd_q == pop_q) begin
						cursor_q <= idx_q[TrackW-1:0]; ok_q <= 1'b1; st_q <= ST_FINAL;
					end else begin
						idx_q <= idx_q + 1'b1; st_q <= ST_SEARCH;
					end
				end
				ST_REPORT: begin
					res_q.ok            <= ok_q;
					res_q.has_track     <= has_cur;
					res_q.current_track <= has_cur ? rd_q : '0;
					res_q.cursor_pos    <= has_cur ? cursor_q : '0;
					res_q.shuffle_state <= shuf_q;
					res_q.history_len   <= fill_q;
					rv_q <= 1'b1;
				end
				default: ;
			endcase
			if (do_push) fill_q <= fill_push;
		end
	end

	// Swap data capture: the entry at pb arrives in RDB.
	always_ff @(posedge clk) begin
		if (st_q == ST_SHUF_RDB) tmpb_q <= rd_q;
	end
endmodule
`default_nettype wire

[hdl/shuffle_playback_queue.sv]
`default_nettype none
// Simple commands pass decode, a read of the cursor entry, a final fetch and
// the report; a shuffle adds a sequential sweep when a new round starts, then
// a draw, a multiply, two reads and two writes per shuffled entry, and a
// previous command searches the table entry by entry. The back part takes one
// command word at a time, limited by the single order-table memory port.
// Reset (arst_n low): empty history, no loaded source, shuffle off, seed default.
module shuffle_playback_queue #(
	parameter int unsigned MAX_TRACKS    = spq_pkg::MaxTracksDef,
	parameter int unsigned HISTORY_DEPTH = spq_pkg::HistoryDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[2:0], start_index[12:3], wrap[13], shuffle_on[14], new_round[15]
	input  wire logic [15:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// ok[0], has_track[1], current_track[11:2], cursor_pos[21:12],
	// shuffle_state[22], history_len[27:23], zero fill above
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	import spq_pkg::*;

	cmd_t q_cmd;
	logic q_valid, q_ready;
	res_t res;

	// The front part unpacks and queues words so the back part can stall alone.
	spq_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_ready, .q_cmd
	);

	spq_back #(.MAX_TRACKS(MAX_TRACKS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.cfg_we, .cfg_index, .cfg_wdata,
		.r_valid(m_tvalid), .r_ready(m_tready), .r_res(res)
	);

	assign m_tdata = {4'd0, res.history_len, res.shuffle_state, res.cursor_pos,
		res.current_track, res.has_track, res.ok};
endmodule
`default_nettype wire

[hdl/spq_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module spq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	// A word with no current track reports zero position and track.
	`SPQ_ASSERT_IMPL(a_none_zero, clk, arst_n, m_tvalid && !m_tdata[1], m_tdata[21:2] == 20'd0, "no track yet nonzero fields")
	`SPQ_ASSERT_IMPL(a_fill_max, clk, arst_n, m_tvalid, m_tdata[27:23] <= 5'd16, "history overflow")
	`SPQ_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
endmodule
bind shuffle_playback_queue spq_checker u_chk (.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata);
`default_nettype wire
